// ===== rtl/ubxr_pkg.sv =====
`timescale 1ns / 1ps

package ubxr_pkg;

   // Buffer size default and framing constants
   localparam int BUF_SIZE_DEF = 512;
   localparam int HEADER_LEN   = 4;
   localparam int LIMIT_MARGIN = 10;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 9;
   localparam int LEN_W   = 16;
   localparam int KIND_W  = 2;

   // Configuration register indexes
   localparam logic [1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN1    = 4'd4,
      PH_LEN2    = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CHK1    = 4'd7,
      PH_CHK2    = 4'd8,
      PH_DROP    = 4'd9
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      EV_BODY     = 2'd0,
      EV_GOOD     = 2'd1,
      EV_BAD      = 2'd2,
      EV_OVERFLOW = 2'd3
   } event_type;

   // One result as it leaves the parser
   typedef struct packed {
      logic               valid;
      event_type          kind;
      logic [BYTE_W-1:0]  body;
      logic [INDEX_W-1:0] index;
   } result_type;

endpackage

// ===== rtl/ubxr_parser.sv =====
`timescale 1ns / 1ps

module ubxr_parser #(
   parameter int BUF_SIZE = ubxr_pkg::BUF_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [ubxr_pkg::BYTE_W-1:0] csr_data,
   input  logic                        byte_valid,
   input  logic [ubxr_pkg::BYTE_W-1:0] rx_byte,
   output ubxr_pkg::result_type        result
);
   import ubxr_pkg::*;

   localparam int CW = $clog2(BUF_SIZE);
   localparam logic [CW-1:0] BODY_LIMIT = CW'(BUF_SIZE - LIMIT_MARGIN);
   localparam int SW = LEN_W + 1;

   phase_type          phase_ff, phase_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [BYTE_W-1:0]  sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0]  sum_b_ff, sum_b_in;
   logic [BYTE_W-1:0]  chk_a_ff, chk_a_in;
   logic [BYTE_W-1:0]  sync1_ff, sync2_ff;

   logic [CW-1:0]      count_inc;
   logic [BYTE_W-1:0]  sum_a_next;
   logic [LEN_W-1:0]   len_full;
   logic [INDEX_W-1:0] count_index;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync1_ff <= 8'd181;
         sync2_ff <= 8'd98;
      end else if (csr_we) begin
         if (csr_index == CSR_SYNC_FIRST) begin
            sync1_ff <= csr_data;
         end
         if (csr_index == CSR_SYNC_SECOND) begin
            sync2_ff <= csr_data;
         end
      end
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         len_ff   <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         chk_a_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         chk_a_ff <= chk_a_in;
      end
   end

   assign count_inc   = count_ff + CW'(1);
   assign sum_a_next  = sum_a_ff + rx_byte;
   assign len_full    = {rx_byte, len_ff[7:0]};
   assign count_index = INDEX_W'(SW'(count_ff));

   // Advance the phase on each accepted byte and build its result where the phase gives one
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      len_in   = len_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      chk_a_in = chk_a_ff;
      result   = '{valid: 1'b0, kind: EV_BODY, body: '0, index: '0};
      if (byte_valid) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == sync1_ff) begin
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               if (rx_byte == sync2_ff) begin
                  phase_in = PH_CLASS;
                  count_in = '0;
                  sum_a_in = '0;
                  sum_b_in = '0;
                  len_in   = '0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_CLASS, PH_ID, PH_LEN1, PH_LEN2, PH_PAYLOAD: begin
               count_in = count_inc;
               sum_a_in = sum_a_next;
               sum_b_in = sum_b_ff + sum_a_next;
               result   = '{valid: 1'b1, kind: EV_BODY, body: rx_byte,
                            index: count_index};
               if (phase_ff == PH_CLASS) begin
                  phase_in = PH_ID;
               end else if (phase_ff == PH_ID) begin
                  phase_in = PH_LEN1;
               end else if (phase_ff == PH_LEN1) begin
                  len_in   = {8'd0, rx_byte};
                  phase_in = PH_LEN2;
               end else if (phase_ff == PH_LEN2) begin
                  len_in   = len_full;
                  phase_in = (len_full == '0) ? PH_CHK1 : PH_PAYLOAD;
               end else if (SW'(count_inc) >= SW'(len_ff) + SW'(HEADER_LEN)) begin
                  phase_in = PH_CHK1;
               end else if (count_inc >= BODY_LIMIT) begin
                  phase_in = PH_DROP;
               end
            end
            PH_CHK1: begin
               chk_a_in = rx_byte;
               phase_in = PH_CHK2;
            end
            PH_CHK2: begin
               phase_in = PH_HUNT;
               result   = '{valid: 1'b1,
                            kind: ((sum_a_ff == chk_a_ff) && (sum_b_ff == rx_byte))
                                  ? EV_GOOD : EV_BAD,
                            body: '0, index: count_index};
            end
            PH_DROP: begin
               phase_in = PH_HUNT;
               result   = '{valid: 1'b1, kind: EV_OVERFLOW, body: '0,
                            index: count_index};
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

endmodule

// ===== rtl/ubxr_out_buf.sv =====
`timescale 1ns / 1ps

module ubxr_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  ubxr_pkg::result_type push,
   output logic                 full,
   output ubxr_pkg::result_type head,
   output logic                 head_valid,
   input  logic                 pop
);
   import ubxr_pkg::*;

   result_type  slot0_ff, slot0_in;
   result_type  slot1_ff, slot1_in;
   logic [1:0]  fill_ff, fill_in;
   logic        do_pop;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head       = slot0_ff;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // Shift out the head and append new results behind it
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      fill_in  = fill_ff + {1'b0, push.valid} - {1'b0, do_pop};
      if (do_pop) begin
         if (fill_ff == 2'd2) begin
            slot0_in = slot1_ff;
         end else begin
            slot0_in = push;
         end
      end else if (push.valid) begin
         if (fill_ff == 2'd0) begin
            slot0_in = push;
         end else begin
            slot1_in = push;
         end
      end
   end

endmodule

// ===== rtl/ubx_frame_receiver.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// req_      in         req_tvalid/req_tready    tdata[7:0] rx_byte
// rsp_      out        rsp_tvalid/rsp_tready    tuser event_kind, tdata body_byte/byte_index
// csr_      in         csr_valid/csr_ready      csr_index, csr_data
//
// One byte is taken per cycle unless stalled; its result is buffered by the next cycle.
// The frame state and Fletcher sums update in the cycle of acceptance.
// Reset is synchronous: phase hunts for the first sync byte, sync values return
// to 0xB5 and 0x62. A two-entry output buffer absorbs a stalled rsp_ side; req_tready
// drops only while both entries are held. csr_ready is always high.

module ubx_frame_receiver #(
   parameter int BUF_SIZE = ubxr_pkg::BUF_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] body_byte, [16:8] byte_index, zero above
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import ubxr_pkg::*;

   result_type result;
   result_type head;
   logic       buf_full;
   logic       accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !buf_full;
   assign accept     = req_tvalid && req_tready;

   ubxr_parser #(
      .BUF_SIZE(BUF_SIZE)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .byte_valid (accept),
      .rx_byte    (req_tdata),
      .result     (result)
   );

   ubxr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (result),
      .full       (buf_full),
      .head       (head),
      .head_valid (rsp_tvalid),
      .pop        (rsp_tready)
   );

   // Drive the result channel from the buffer head
   assign rsp_tuser = head.kind;
   assign rsp_tdata = {7'd0, head.index, head.body};

`ifndef NO_ASSERTIONS
   a_full_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   a_result_shows: assert property (@(posedge clock) disable iff (reset)
      result.valid |=> rsp_tvalid)
      else $error("produced result not presented");

   a_end_zero_body: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != EV_BODY) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("end event carries a body byte");

   a_no_result_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |-> !result.valid)
      else $error("result without an accepted request");
`endif

endmodule

// ===== tb/sv/tb_ubx_frame_receiver.sv =====
`timescale 1ns / 1ps

module tb_ubx_frame_receiver;
   import ubxr_pkg::*;

   localparam int          BODY_LIMIT    = BUF_SIZE_DEF - LIMIT_MARGIN;
   localparam int          MAX_FIT_LEN   = BODY_LIMIT - HEADER_LEN;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          ERR_PRINT_MAX = 40;
   localparam int          CHUNK_ITEMS   = 45;
   localparam logic [1:0]  CSR_SPARE     = 2'd3;

   // One result of the parser as the checker sees it
   typedef struct packed {
      event_type   kind;
      logic [7:0]  body;
      logic [8:0]  index;
   } frame_event_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;   // [7:0] body_byte, [16:8] byte_index, zero above
   logic [1:0]  rsp_tuser;   // [1:0] event_kind
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = 2'd0;
   logic [7:0]  csr_data   = 8'h00;

   // Byte stream still to send and results still owed by the parser
   logic [7:0]      rx_stream[$];
   frame_event_type expected_events[$];

   // Shadow of the parser: sync settings and frame state
   logic [7:0] cfg_first  = 8'hB5;
   logic [7:0] cfg_second = 8'h62;
   phase_type  rx_phase   = PH_HUNT;
   int         body_cnt   = 0;
   int         frame_len  = 0;
   logic [7:0] fl_a       = 8'h00;
   logic [7:0] fl_b       = 8'h00;
   logic [7:0] check_a_rx = 8'h00;

   bit calm_tail   = 1'b0;
   int send_gap    = 0;
   int stall_left  = 0;
   int cycle_count = 0;
   int error_count = 0;
   int bytes_sent  = 0;
   int body_seen   = 0;
   int good_seen   = 0;
   int bad_seen    = 0;
   int drop_seen   = 0;

   ubx_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the shadow parser by one received byte and queue its result
   task automatic parse_rx_byte(input logic [7:0] rx);
      frame_event_type ev;
      bit              emits;
      emits = 1'b0;
      ev    = '0;
      case (rx_phase)
         PH_HUNT: begin
            if (rx == cfg_first) rx_phase = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (rx == cfg_second) begin
               rx_phase  = PH_CLASS;
               body_cnt  = 0;
               fl_a      = 8'h00;
               fl_b      = 8'h00;
               frame_len = 0;
            end else begin
               rx_phase = PH_HUNT;
            end
         end
         PH_CLASS, PH_ID, PH_LEN1, PH_LEN2, PH_PAYLOAD: begin
            ev.kind  = EV_BODY;
            ev.body  = rx;
            ev.index = body_cnt[8:0];
            emits    = 1'b1;
            fl_a     = fl_a + rx;
            fl_b     = fl_b + fl_a;
            body_cnt = body_cnt + 1;
            if (rx_phase == PH_CLASS) begin
               rx_phase = PH_ID;
            end else if (rx_phase == PH_ID) begin
               rx_phase = PH_LEN1;
            end else if (rx_phase == PH_LEN1) begin
               frame_len = rx;
               rx_phase  = PH_LEN2;
            end else if (rx_phase == PH_LEN2) begin
               frame_len = frame_len | (int'(rx) << 8);
               rx_phase  = (frame_len == 0) ? PH_CHK1 : PH_PAYLOAD;
            end else if (body_cnt >= frame_len + HEADER_LEN) begin
               rx_phase = PH_CHK1;
            end else if (body_cnt >= BODY_LIMIT) begin
               rx_phase = PH_DROP;
            end
         end
         PH_CHK1: begin
            check_a_rx = rx;
            rx_phase   = PH_CHK2;
         end
         PH_CHK2: begin
            ev.kind  = (fl_a == check_a_rx && fl_b == rx) ? EV_GOOD : EV_BAD;
            ev.index = body_cnt[8:0];
            emits    = 1'b1;
            rx_phase = PH_HUNT;
         end
         PH_DROP: begin
            ev.kind  = EV_OVERFLOW;
            ev.index = body_cnt[8:0];
            emits    = 1'b1;
            rx_phase = PH_HUNT;
         end
         default: rx_phase = PH_HUNT;
      endcase
      if (emits) expected_events.push_back(ev);
   endtask

   // Build one frame with the current sync bytes; an oversize length is cut
   // at the buffer limit and followed by the byte that gets dropped
   task automatic push_frame(input logic [7:0] cls, input logic [7:0] id,
                             input int len, input bit spoil_sum);
      logic [7:0]  body_q[$];
      logic [15:0] len16;
      logic [7:0]  ck_a;
      logic [7:0]  ck_b;
      int          n_pay;
      bit          overflow;
      len16    = len[15:0];
      overflow = (len > MAX_FIT_LEN);
      n_pay    = overflow ? MAX_FIT_LEN + 1 : len;
      body_q   = {cls, id, len16[7:0], len16[15:8]};
      for (int i = 0; i < n_pay; i++) body_q.push_back(8'($urandom));
      ck_a = 8'h00;
      ck_b = 8'h00;
      rx_stream.push_back(cfg_first);
      rx_stream.push_back(cfg_second);
      foreach (body_q[i]) begin
         rx_stream.push_back(body_q[i]);
         ck_a = ck_a + body_q[i];
         ck_b = ck_b + ck_a;
      end
      if (!overflow) begin
         if (spoil_sum) begin
            if ($urandom_range(0, 1) == 0) ck_a = ck_a ^ (8'h01 << $urandom_range(0, 7));
            else ck_b = ck_b ^ (8'h01 << $urandom_range(0, 7));
         end
         rx_stream.push_back(ck_a);
         rx_stream.push_back(ck_b);
      end
   endtask

   // Mostly well-formed frames, with some bad sums, line noise, false syncs
   // and cut-off frames; only bytes that reach a frame count toward budget
   task automatic queue_random_traffic(input int budget);
      int         framed;
      int         before_n;
      int         pick;
      int         len;
      int         k;
      logic [7:0] b;
      framed = 0;
      while (framed < budget) begin
         pick     = $urandom_range(0, 99);
         len      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
         before_n = rx_stream.size();
         if (pick < 72) begin
            push_frame(8'($urandom), 8'($urandom), len, 1'b0);
         end else if (pick < 84) begin
            push_frame(8'($urandom), 8'($urandom), len, 1'b1);
         end else if (pick < 92) begin
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++) begin
               do b = 8'($urandom); while (b == cfg_first);
               rx_stream.push_back(b);
            end
            before_n = rx_stream.size();
         end else if (pick < 96) begin
            do b = 8'($urandom); while (b == cfg_second);
            rx_stream.push_back(cfg_first);
            rx_stream.push_back(b);
            before_n = rx_stream.size();
         end else begin
            len = $urandom_range(1, 8);
            rx_stream.push_back(cfg_first);
            rx_stream.push_back(cfg_second);
            rx_stream.push_back(8'($urandom));
            rx_stream.push_back(8'($urandom));
            rx_stream.push_back(8'(len));
            rx_stream.push_back(8'h00);
            k = $urandom_range(0, len - 1);
            for (int i = 0; i < k; i++) rx_stream.push_back(8'($urandom));
         end
         framed += rx_stream.size() - before_n;
      end
   endtask

   // Hold until every byte is taken and every result is in, then let the
   // output buffer settle
   task automatic wait_for_drain();
      do @(negedge clock);
      while (rx_stream.size() != 0 || req_tvalid || expected_events.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // Write one sync register through the register channel
   task automatic write_sync_reg(input logic [1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SYNC_FIRST) cfg_first = val;
      else if (idx == CSR_SYNC_SECOND) cfg_second = val;
   endtask

   task automatic report_field(input string name, input int want, input int got);
      if (error_count < ERR_PRINT_MAX)
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
   endtask

   // Request driver: present the next byte, with short random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_rx_byte(req_tdata);
            bytes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (rx_stream.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= rx_stream.pop_front();
               if (!calm_tail && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 3);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side back-pressure in short bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each delivered result with the oldest one owed
   always @(posedge clock) begin : check_results
      frame_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            if (error_count < ERR_PRINT_MAX)
               $error("unexpected result: event_kind %0d, tdata 0x%06h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser !== want.kind) report_field("event_kind", want.kind, rsp_tuser);
            if (rsp_tdata[7:0] !== want.body) report_field("body_byte", want.body, rsp_tdata[7:0]);
            if (rsp_tdata[16:8] !== want.index)
               report_field("byte_index", want.index, rsp_tdata[16:8]);
            if (rsp_tdata[23:17] !== 7'd0) report_field("tdata padding", 0, rsp_tdata[23:17]);
            case (want.kind)
               EV_BODY:  body_seen++;
               EV_GOOD:  good_seen++;
               EV_BAD:   bad_seen++;
               default:  drop_seen++;
            endcase
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_events.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      // Directed: byte extremes, a false sync where the repeat is not
      // rechecked, an empty frame and a one-byte frame with a bad sum
      rx_stream.push_back(8'h00);
      rx_stream.push_back(8'hFF);
      rx_stream.push_back(cfg_first);
      rx_stream.push_back(cfg_first);
      rx_stream.push_back(cfg_second);
      push_frame(8'h00, 8'hFF, 0, 1'b0);
      push_frame(8'hFF, 8'h00, 1, 1'b1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Buffer limit: a frame that ends exactly at it, then one that overflows
      wait_for_drain();
      push_frame(8'h01, 8'h07, MAX_FIT_LEN, 1'b0);
      push_frame(8'h0A, 8'h0B, 16'hFFFF, 1'b0);
      queue_random_traffic(CHUNK_ITEMS);

      wait_for_drain();
      write_sync_reg(CSR_SYNC_FIRST, 8'h00);
      write_sync_reg(CSR_SYNC_SECOND, 8'hFF);
      write_sync_reg(CSR_SPARE, 8'h5A);
      queue_random_traffic(CHUNK_ITEMS);

      wait_for_drain();
      write_sync_reg(CSR_SYNC_FIRST, 8'hFF);
      write_sync_reg(CSR_SYNC_SECOND, 8'h00);
      queue_random_traffic(CHUNK_ITEMS);

      wait_for_drain();
      write_sync_reg(CSR_SYNC_FIRST, 8'($urandom));
      write_sync_reg(CSR_SYNC_SECOND, 8'($urandom));
      queue_random_traffic(CHUNK_ITEMS);

      // Identical sync bytes
      wait_for_drain();
      write_sync_reg(CSR_SYNC_FIRST, 8'h55);
      write_sync_reg(CSR_SYNC_SECOND, 8'h55);
      queue_random_traffic(CHUNK_ITEMS);

      // Back to the standard sync pair, no idling on either side
      wait_for_drain();
      write_sync_reg(CSR_SYNC_FIRST, 8'hB5);
      write_sync_reg(CSR_SYNC_SECOND, 8'h62);
      calm_tail = 1'b1;
      queue_random_traffic(CHUNK_ITEMS);

      wait_for_drain();
      repeat (12) @(negedge clock);
      if (expected_events.size() != 0) begin
         $error("%0d results never arrived", expected_events.size());
         error_count++;
      end

      $display("Sent %0d bytes over six sync settings; checked %0d body bytes", bytes_sent,
               body_seen);
      $display("Frame ends: %0d good, %0d bad checksum, %0d overflow", good_seen, bad_seen,
               drop_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
